/* hdl/tcp_fingerprint_table_match_macros.svh */
// Assertion macros shared by the checker of the fingerprint table matcher.
// Holds only macro definitions; no dependencies.
`ifndef TCP_FINGERPRINT_TABLE_MATCH_MACROS_SVH
`define TCP_FINGERPRINT_TABLE_MATCH_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define TFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define TFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tfm_pkg.sv */
// Package of the fingerprint table matcher: sizes, command, status and state codes, query type.
// No dependencies.
`default_nettype none
package tfm_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned MaxOptions   = 8;
  localparam logic [7:0]  TolReset     = 8'd5;

  typedef enum logic [2:0] {
    CMD_CLEAR  = 3'd0,
    CMD_EHDR   = 3'd1,
    CMD_EOPT   = 3'd2,
    CMD_QHDR   = 3'd3,
    CMD_QOPT   = 3'd4,
    CMD_RUN    = 3'd5,
    CMD_NOP6   = 3'd6,
    CMD_NOP7   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_NONE  = 2'd1,
    ST_QOVER = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_OUT
  } fsm_e;

  // Query as broadcast to all cells.
  typedef struct packed {
    logic [7:0]  ttl;
    logic [15:0] window;
    logic [7:0]  tol;
  } query_t;
endpackage
`default_nettype wire

/* hdl/tfm_cell.sv */
// One table entry cell: stores an entry and tests it against the query.
// Depends on tfm_pkg.
`default_nettype none
module tfm_cell
  import tfm_pkg::*;
#(
  parameter int unsigned MAX_OPTIONS = MaxOptions,
  localparam int unsigned CW = $clog2(MAX_OPTIONS + 1),
  localparam int unsigned OW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          clear_i,
  input  wire logic                          hdr_we_i,
  input  wire logic                          opt_we_i,
  input  wire logic [7:0]                    ttl_i,
  input  wire logic [15:0]                   window_i,
  input  wire logic [7:0]                    label_i,
  input  wire logic [7:0]                    kind_i,
  input  wire query_t                        query_i,
  input  wire logic [CW-1:0]                 qcount_i,
  input  wire logic [MAX_OPTIONS-1:0][7:0]   qopts_i,
  output logic                               hit_o,
  output logic [7:0]                         label_o
);
  logic              valid_q, over_q;
  logic [CW-1:0]     count_q;
  logic [7:0]        ttl_q, label_q;
  logic [15:0]       window_q;
  logic [MAX_OPTIONS-1:0][7:0] opts_q;
  logic [8:0]        diff;
  logic              ms_ok;

  // Control state of the entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      over_q  <= 1'b0;
      count_q <= '0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
      over_q  <= 1'b0;
      count_q <= '0;
    end else if (hdr_we_i) begin
      valid_q <= 1'b1;
      over_q  <= 1'b0;
      count_q <= '0;
    end else if (opt_we_i) begin
      if (count_q < CW'(MAX_OPTIONS)) count_q <= count_q + 1'b1;
      else over_q <= 1'b1;
    end
  end

  // Payload of the entry.
  always_ff @(posedge clk_i) begin
    if (hdr_we_i) begin
      ttl_q    <= ttl_i;
      window_q <= window_i;
      label_q  <= label_i;
    end
    if (opt_we_i && !clear_i && !hdr_we_i && count_q < CW'(MAX_OPTIONS)) begin
      opts_q[count_q[OW-1:0]] <= kind_i;
    end
  end

  // Multiset test: each entry option occurs equally often in both lists.
  always_comb begin
    logic [CW-1:0] ce, cq;
    ms_ok = 1'b1;
    for (int i = 0; i < MAX_OPTIONS; i++) begin
      ce = '0;
      cq = '0;
      for (int j = 0; j < MAX_OPTIONS; j++) begin
        if (j < int'(count_q) && opts_q[j] == opts_q[i]) ce = ce + 1'b1;
        if (j < int'(count_q) && qopts_i[j] == opts_q[i]) cq = cq + 1'b1;
      end
      if (i < int'(count_q) && ce != cq) ms_ok = 1'b0;
    end
  end

  assign diff = ({1'b0, ttl_q} >= {1'b0, query_i.ttl}) ?
                ({1'b0, ttl_q} - {1'b0, query_i.ttl}) :
                ({1'b0, query_i.ttl} - {1'b0, ttl_q});
  assign hit_o = valid_q && !over_q && (diff <= {1'b0, query_i.tol}) &&
                 (window_q == query_i.window) && (count_q == qcount_i) && ms_ok;
  assign label_o = label_q;
endmodule
`default_nettype wire

/* hdl/tfm_scan.sv */
// Scan stage: a row of hit flags shifted toward the head one cell per cycle while shift_i is high.
// Depends on tfm_pkg.
`default_nettype none
module tfm_scan
  import tfm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntries,
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               load_i,
  input  wire logic                               shift_i,
  input  wire logic [TABLE_ENTRIES-1:0]           hit_i,
  input  wire logic [TABLE_ENTRIES-1:0][7:0]      label_i,
  output logic                                    head_hit_o,
  output logic [7:0]                              head_label_o,
  output logic [IW-1:0]                           head_index_o
);
  logic [TABLE_ENTRIES-1:0]           hit_q;
  logic [TABLE_ENTRIES-1:0][7:0]      lab_q;
  logic [TABLE_ENTRIES-1:0][IW-1:0]   idx_q;

  // Each cell hands its flag, label and index to its lower neighbor.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (load_i) begin
        hit_q[i] <= hit_i[i];
        lab_q[i] <= label_i[i];
        idx_q[i] <= IW'(i);
      end else if (shift_i) begin
        if (i == TABLE_ENTRIES - 1) begin
          hit_q[i] <= 1'b0;
        end else begin
          hit_q[i] <= hit_q[i+1];
          lab_q[i] <= lab_q[i+1];
          idx_q[i] <= idx_q[i+1];
        end
      end
    end
  end

  assign head_hit_o   = hit_q[0];
  assign head_label_o = lab_q[0];
  assign head_index_o = idx_q[0];
endmodule
`default_nettype wire

/* hdl/tcp_fingerprint_table_match.sv */
// Commands other than a run are taken while idle and give no item. A run with a query
// list overflow goes straight to the output state; otherwise the hit flags of all
// entries are loaded into the scan row and shifted toward the head until a hit reaches
// it or the row is used up. One item at a time: the input stalls while a run scans or
// its result waits, and the next item is taken once the result is taken. Reset clears
// the table, the query and the tolerance (back to 5).
`default_nettype none
module tcp_fingerprint_table_match
  import tfm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntries,
  parameter int unsigned MAX_OPTIONS   = MaxOptions
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  cmd_i,
  input  wire logic [3:0]  index_i,
  input  wire logic [7:0]  ttl_value_i,
  input  wire logic [15:0] window_value_i,
  input  wire logic [7:0]  os_label_i,
  input  wire logic [7:0]  option_kind_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [3:0]       match_index_o,
  output logic [7:0]       matched_label_o
);
  localparam int unsigned CW = $clog2(MAX_OPTIONS + 1);
  localparam int unsigned OW = (MAX_OPTIONS > 1) ? $clog2(MAX_OPTIONS) : 1;
  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CCW = $clog2(TABLE_ENTRIES + 1);

  fsm_e state_q, state_d;
  logic [7:0]  tol_q;
  logic [7:0]  qttl_q;
  logic [15:0] qwin_q;
  logic [CW-1:0] qcnt_q;
  logic        qover_q;
  logic [MAX_OPTIONS-1:0][7:0] qopts_q;
  logic [CCW-1:0] left_q;
  logic [1:0]  st_q;
  logic [3:0]  idx_q;
  logic [7:0]  lab_q;
  logic        acc, is_run, load, shift, done_hit, done_miss;
  query_t      query;
  logic [TABLE_ENTRIES-1:0]      hits;
  logic [TABLE_ENTRIES-1:0][7:0] labels;
  logic        head_hit;
  logic [7:0]  head_label;
  logic [IW-1:0] head_index;
  cmd_e        cmd;

  assign cmd         = cmd_e'(cmd_i);
  assign cfg_ready_o = (state_q == FSM_IDLE);
  assign acc         = in_valid_i && !in_stall_o;
  assign is_run      = acc && (cmd == CMD_RUN);
  assign load        = is_run && !qover_q;
  assign shift       = (state_q == FSM_SCAN) && !head_hit;
  assign done_hit    = (state_q == FSM_SCAN) && head_hit;
  assign done_miss   = (state_q == FSM_SCAN) && !head_hit && (left_q <= CCW'(1));
  assign query       = '{ttl: qttl_q, window: qwin_q, tol: tol_q};

  // Row of entry cells.
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    logic sel;
    assign sel = acc && ({{(32-4){1'b0}}, index_i} == g);
    tfm_cell #(.MAX_OPTIONS(MAX_OPTIONS)) u_cell (
      .clk_i, .rst_ni,
      .clear_i  (acc && cmd == CMD_CLEAR),
      .hdr_we_i (sel && cmd == CMD_EHDR),
      .opt_we_i (sel && cmd == CMD_EOPT),
      .ttl_i    (ttl_value_i),
      .window_i (window_value_i),
      .label_i  (os_label_i),
      .kind_i   (option_kind_i),
      .query_i  (query),
      .qcount_i (qcnt_q),
      .qopts_i  (qopts_q),
      .hit_o    (hits[g]),
      .label_o  (labels[g])
    );
  end

  tfm_scan #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_scan (
    .clk_i, .load_i(load), .shift_i(shift), .hit_i(hits), .label_i(labels),
    .head_hit_o(head_hit), .head_label_o(head_label), .head_index_o(head_index)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: if (is_run) state_d = qover_q ? FSM_OUT : FSM_SCAN;
      FSM_SCAN: if (done_hit || done_miss) state_d = FSM_OUT;
      FSM_OUT:  if (!out_stall_i) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: in_stall_o  = 1'b0;
      FSM_SCAN: in_stall_o  = 1'b1;
      FSM_OUT:  out_valid_o = 1'b1;
      default:  in_stall_o  = 1'b1;
    endcase
  end

  // Control and query registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      tol_q   <= TolReset;
      qttl_q  <= '0;
      qwin_q  <= '0;
      qcnt_q  <= '0;
      qover_q <= 1'b0;
      left_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) tol_q <= cfg_data_i;
      if (acc && cmd == CMD_QHDR) begin
        qttl_q  <= ttl_value_i;
        qwin_q  <= window_value_i;
        qcnt_q  <= '0;
        qover_q <= 1'b0;
      end else if (acc && cmd == CMD_QOPT) begin
        if (qcnt_q < CW'(MAX_OPTIONS)) qcnt_q <= qcnt_q + 1'b1;
        else qover_q <= 1'b1;
      end
      if (load) left_q <= CCW'(TABLE_ENTRIES);
      else if (shift) left_q <= left_q - 1'b1;
    end
  end

  // Query option slots and the result register.
  always_ff @(posedge clk_i) begin
    if (acc && cmd == CMD_QOPT && qcnt_q < CW'(MAX_OPTIONS)) begin
      qopts_q[qcnt_q[OW-1:0]] <= option_kind_i;
    end
    if (is_run && qover_q) begin
      st_q <= ST_QOVER; idx_q <= '0; lab_q <= '0;
    end else if (done_hit) begin
      st_q <= ST_MATCH; idx_q <= 4'(head_index); lab_q <= head_label;
    end else if (done_miss) begin
      st_q <= ST_NONE; idx_q <= '0; lab_q <= '0;
    end
  end

  assign status_o        = st_q;
  assign match_index_o   = idx_q;
  assign matched_label_o = lab_q;
endmodule
`default_nettype wire

/* hdl/tfm_checker.sv */
// Port checker of the fingerprint table matcher, bound to the top level.
// Depends on tfm_pkg and the macro header.
`default_nettype none
`include "tcp_fingerprint_table_match_macros.svh"
module tfm_checker
  import tfm_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [2:0] cmd_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [1:0] status_o,
  input wire logic [3:0] match_index_o,
  input wire logic [7:0] matched_label_o
);
  // A run item leaves the input side closed until its result is taken.
  `TFM_ASSERT_NEXT(a_run_stalls, clk_i, rst_ni,
    in_valid_i && !in_stall_o && cmd_i == CMD_RUN, in_stall_o, "run not stalling")
  // No input is taken while a result waits.
  `TFM_ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, in_stall_o, "input while output")
  // A non-match result carries zero index and label.
  `TFM_ASSERT_IMPL(a_zero, clk_i, rst_ni, out_valid_o && status_o != ST_MATCH,
    match_index_o == 4'd0 && matched_label_o == 8'd0, "nonzero miss fields")
  // Status never shows the unused code.
  `TFM_ASSERT_IMPL(a_stat, clk_i, rst_ni, out_valid_o, status_o != ST_RSVD, "bad status")
endmodule

bind tcp_fingerprint_table_match tfm_checker u_tfm_checker (.*);
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the TCP fingerprint table matcher.
// Depends on tfm_pkg and tcp_fingerprint_table_match; predicts each run item and
// compares it with what the block returns.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tfm_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 40;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] idx;
    logic [7:0] label;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  cmd_i = '0;
  logic [3:0]  index_i = '0;
  logic [7:0]  ttl_value_i = '0;
  logic [15:0] window_value_i = '0;
  logic [7:0]  os_label_i = '0;
  logic [7:0]  option_kind_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [3:0]  match_index_o;
  logic [7:0]  matched_label_o;

  tcp_fingerprint_table_match dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .cmd_i, .index_i, .ttl_value_i, .window_value_i,
    .os_label_i, .option_kind_i, .out_valid_o, .out_stall_i, .status_o,
    .match_index_o, .matched_label_o
  );

  always #10 clk_i = ~clk_i;

  // Mirror of the block's table, query and tolerance.
  logic [7:0]  tol_q;
  logic        tab_valid[TableEntries];
  logic [7:0]  tab_ttl[TableEntries];
  logic [15:0] tab_win[TableEntries];
  logic [7:0]  tab_label[TableEntries];
  int          tab_cnt[TableEntries];
  logic        tab_over[TableEntries];
  logic [7:0]  tab_opt[TableEntries][MaxOptions];
  logic [7:0]  q_ttl;
  logic [15:0] q_win;
  int          q_cnt;
  logic        q_over;
  logic [7:0]  q_opt[MaxOptions];

  verdict_t pending_verdicts[$];
  int  mismatches = 0;
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  bit  hold_off = 1'b0;
  int  idle_cycles = 0;

  function automatic bit same_options(int e);
    int a;
    int b;
    if (tab_cnt[e] != q_cnt) return 1'b0;
    for (int i = 0; i < tab_cnt[e]; i++) begin
      a = 0;
      b = 0;
      for (int j = 0; j < q_cnt; j++) begin
        if (tab_opt[e][j] == tab_opt[e][i]) a++;
        if (q_opt[j] == tab_opt[e][i]) b++;
      end
      if (a != b) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one command to the mirror and queues the run verdict if any.
  task automatic predict_command(logic [2:0] c, logic [3:0] ix, logic [7:0] t,
                                 logic [15:0] w, logic [7:0] l, logic [7:0] k);
    verdict_t v;
    int diff;
    case (cmd_e'(c))
      CMD_CLEAR: begin
        for (int e = 0; e < TableEntries; e++) begin
          tab_valid[e] = 1'b0;
          tab_cnt[e] = 0;
          tab_over[e] = 1'b0;
        end
      end
      CMD_EHDR: begin
        tab_valid[ix] = 1'b1;
        tab_ttl[ix] = t;
        tab_win[ix] = w;
        tab_label[ix] = l;
        tab_cnt[ix] = 0;
        tab_over[ix] = 1'b0;
      end
      CMD_EOPT: begin
        if (tab_cnt[ix] < MaxOptions) begin
          tab_opt[ix][tab_cnt[ix]] = k;
          tab_cnt[ix]++;
        end else tab_over[ix] = 1'b1;
      end
      CMD_QHDR: begin
        q_ttl = t;
        q_win = w;
        q_cnt = 0;
        q_over = 1'b0;
      end
      CMD_QOPT: begin
        if (q_cnt < MaxOptions) begin
          q_opt[q_cnt] = k;
          q_cnt++;
        end else q_over = 1'b1;
      end
      CMD_RUN: begin
        v = '{ST_NONE, 4'd0, 8'd0};
        if (q_over) v.status = ST_QOVER;
        else begin
          for (int e = 0; e < TableEntries; e++) begin
            if (!tab_valid[e] || tab_over[e]) continue;
            diff = int'(tab_ttl[e]) - int'(q_ttl);
            if (diff < 0) diff = -diff;
            if (diff <= int'(tol_q) && tab_win[e] == q_win && same_options(e)) begin
              v = '{ST_MATCH, 4'(e), tab_label[e]};
              break;
            end
          end
        end
        pending_verdicts.push_back(v);
      end
      default: ;
    endcase
  endtask

  // Sends one item and waits until the block takes it; valid drops only in idle cycles.
  task automatic send_command(cmd_e c, int ix = 0, int t = 0, int w = 0, int l = 0,
                              int k = 0);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    index_i        <= 4'(ix);
    ttl_value_i    <= 8'(t);
    window_value_i <= 16'(w);
    os_label_i     <= 8'(l);
    option_kind_i  <= 8'(k);
    do @(posedge clk_i); while (in_stall_o);
    predict_command(c, 4'(ix), 8'(t), 16'(w), 8'(l), 8'(k));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_tolerance(int value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= 8'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    tol_q = 8'(value);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes a full entry: header plus a list of option kinds.
  task automatic load_entry(int ix, int t, int w, int l, int n, int kinds[MaxOptions + 2]);
    send_command(CMD_EHDR, ix, t, w, l);
    for (int i = 0; i < n; i++) send_command(CMD_EOPT, ix, 0, 0, 0, kinds[i]);
  endtask

  // Receiver stall control: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  // Checks each returned verdict against the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: status %0d index %0d label %0d",
                                       status_o, match_index_o, matched_label_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (status_o !== want.status || match_index_o !== want.idx ||
            matched_label_o !== want.label) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d", want.status,
                     want.idx, want.label, status_o, match_index_o, matched_label_o);
        end
      end
    end
  end

  // Watchdog over cycles in which neither side moves an item.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_off)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic test_directed();
    int kinds[MaxOptions + 2];
    for (int i = 0; i < MaxOptions + 2; i++) kinds[i] = i * 37 % 256;
    kinds[1] = 255;
    kinds[2] = 0;
    send_command(CMD_RUN);                           // empty table, empty query
    load_entry(0, 64, 65535, 255, 3, kinds);
    load_entry(15, 255, 0, 1, MaxOptions, kinds);
    send_command(CMD_EOPT, 14, 0, 0, 0, 9);          // option to an invalid entry
    send_command(CMD_EOPT, 15, 0, 0, 0, 1);          // entry list overflow
    send_command(CMD_QHDR, 0, 69, 65535);
    send_command(CMD_QOPT, 0, 0, 0, 0, kinds[2]);
    send_command(CMD_QOPT, 0, 0, 0, 0, kinds[0]);
    send_command(CMD_QOPT, 0, 0, 0, 0, kinds[1]);
    send_command(CMD_RUN);                           // match at tolerance edge
    send_command(CMD_NOP6);
    send_command(CMD_NOP7, 15, 255, 65535, 255, 255);
    send_command(CMD_QHDR, 0, 70, 65535);
    send_command(CMD_RUN);                           // one beyond tolerance
    send_command(CMD_QHDR, 0, 255, 0);
    for (int i = 0; i < MaxOptions + 1; i++) send_command(CMD_QOPT, 0, 0, 0, 0, i);
    send_command(CMD_RUN);                           // query list overflow
    send_command(CMD_CLEAR);
    send_command(CMD_RUN);
  endtask

  task automatic test_tolerance_extremes();
    int kinds[MaxOptions + 2];
    kinds = '{default: 0};
    write_tolerance(0);
    load_entry(3, 0, 100, 7, 0, kinds);
    send_command(CMD_QHDR, 0, 0, 100);
    send_command(CMD_RUN);
    write_tolerance(255);
    send_command(CMD_QHDR, 0, 255, 100);
    send_command(CMD_RUN);
  endtask

  // Random table loads and queries; queries are often copies of an entry.
  task automatic random_block(int items);
    int sent = 0;
    int e;
    int n;
    int kinds[MaxOptions + 2];
    while (sent < items) begin
      case ($urandom_range(9))
        0: begin
          send_command(cmd_e'($urandom_range(7)), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
          sent++;
        end
        1, 2, 3: begin
          n = $urandom_range(MaxOptions + ($urandom_range(5) == 0 ? 2 : 0));
          for (int i = 0; i < n; i++) kinds[i] = $urandom_range(3) == 0 ? $urandom : $urandom_range(3);
          load_entry($urandom_range(15), $urandom_range(60, 70), $urandom_range(1) ? 16'hFFFF :
                     $urandom, $urandom, n, kinds);
          sent += n + 1;
        end
        default: begin
          e = $urandom_range(15);
          if (!tab_valid[e] || $urandom_range(4) == 0) begin
            send_command(CMD_QHDR, 0, $urandom_range(55, 75), $urandom_range(1) ? 16'hFFFF : $urandom);
            n = $urandom_range(MaxOptions + 1);
            for (int i = 0; i < n; i++) send_command(CMD_QOPT, 0, 0, 0, 0, $urandom_range(3));
          end else begin
            n = tab_cnt[e];
            for (int i = 0; i < n; i++) kinds[i] = tab_opt[e][i];
            for (int i = n - 1; i > 0; i--) begin
              int j;
              int s;
              j = $urandom_range(i);
              s = kinds[i];
              kinds[i] = kinds[j];
              kinds[j] = s;
            end
            if (n > 0 && $urandom_range(5) == 0) kinds[0] = kinds[0] ^ 1;
            send_command(CMD_QHDR, 0, int'(tab_ttl[e]) + $urandom_range(10) - 5, tab_win[e]);
            for (int i = 0; i < n; i++) send_command(CMD_QOPT, 0, 0, 0, 0, kinds[i]);
          end
          send_command(CMD_RUN);
          sent += n + 2;
          if ($urandom_range(40) == 0) begin
            send_command(CMD_CLEAR);
            sent++;
          end
        end
      endcase
    end
  endtask

  task automatic test_random();
    write_tolerance(5);
    send_idle_pct = 0;  stall_pct = 0;  random_block(250);
    send_idle_pct = 69; stall_pct = 0;  random_block(250);
    write_tolerance($urandom_range(1, 254));
    send_idle_pct = 0;  stall_pct = 69; random_block(250);
    send_idle_pct = 24; stall_pct = 24; random_block(250);
  endtask

  // Receiver holds off while runs keep coming, then the sender waits it out.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_command(CMD_RUN);
    join
    wait_drained();
  endtask

  initial begin
    for (int e = 0; e < TableEntries; e++) begin
      tab_valid[e] = 1'b0;
      tab_cnt[e] = 0;
      tab_over[e] = 1'b0;
    end
    tol_q = TolReset;
    q_ttl = '0;
    q_win = '0;
    q_cnt = 0;
    q_over = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_tolerance_extremes();
    test_random();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && pending_verdicts.size() == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

/* tcp_fingerprint_table_match.f */
+incdir+hdl
hdl/tfm_pkg.sv
hdl/tfm_cell.sv
hdl/tfm_scan.sv
hdl/tcp_fingerprint_table_match.sv
hdl/tfm_checker.sv
test/testbench.sv
